/* hw/rtl/ctpd_pkg.sv */
// ----------------------------------------------------------------------------
// Charger tone presence detector package
// Shared types and constants for the detector and its register file.
// ----------------------------------------------------------------------------
package ctpd_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned RegIdxW = 3;

  localparam logic [CntW-1:0] CntMax = 16'hFFFF;

  typedef enum logic [RegIdxW-1:0] {
    REG_HALF_PERIOD_MIN   = 3'd0,
    REG_HALF_PERIOD_MAX   = 3'd1,
    REG_WINDOW_TICKS      = 3'd2,
    REG_PRESENT_THRESHOLD = 3'd3,
    REG_ABSENT_THRESHOLD  = 3'd4,
    REG_CHARGING_CONFIRM  = 3'd5,
    REG_DONE_CONFIRM      = 3'd6,
    REG_IDLE_TIMEOUT      = 3'd7
  } reg_idx_e;

  localparam logic [CntW-1:0] HalfPeriodMinRst    = 16'd3;
  localparam logic [CntW-1:0] HalfPeriodMaxRst    = 16'd5;
  localparam logic [CntW-1:0] WindowTicksRst      = 16'd100;
  localparam logic [CntW-1:0] PresentThresholdRst = 16'd16;
  localparam logic [CntW-1:0] AbsentThresholdRst  = 16'd10;
  localparam logic [CntW-1:0] ChargingConfirmRst  = 16'd100;
  localparam logic [CntW-1:0] DoneConfirmRst      = 16'd50000;
  localparam logic [CntW-1:0] IdleTimeoutRst      = 16'd20000;

  typedef struct packed {
    logic [CntW-1:0] half_period_min;
    logic [CntW-1:0] half_period_max;
    logic [CntW-1:0] window_ticks;
    logic [CntW-1:0] present_threshold;
    logic [CntW-1:0] absent_threshold;
    logic [CntW-1:0] charging_confirm;
    logic [CntW-1:0] done_confirm;
    logic [CntW-1:0] idle_timeout;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_INIT = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

endpackage

/* hw/rtl/charger_tone_presence_detector.sv */
// ----------------------------------------------------------------------------
// Charger tone presence detector
// A result is registered and is valid in the cycle after its sample is taken in.
// Throughput: one sample per cycle while the output is not stalled.
// The output register frees the input whenever the result is taken.
// Reset clears all run, window and presence state and restores the registers.
// ----------------------------------------------------------------------------
module charger_tone_presence_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ctpd_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [ctpd_pkg::CntW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         pin_level_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         charging_o,
  output logic                         charge_done_o,
  output logic                         tone_present_o
);

  localparam int unsigned W = ctpd_pkg::CntW;

  ctpd_pkg::cfg_t cfg;

  ctpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ctpd_pkg::phase_e phase_q, phase_d;
  logic [W-1:0] high_run_q, high_run_d;
  logic [W-1:0] low_run_q, low_run_d;
  logic [W-1:0] window_count_q, window_count_d;
  logic [W-1:0] valid_halves_q, valid_halves_d;
  logic [W-1:0] presence_count_q, presence_count_d;
  logic [W-1:0] idle_count_q, idle_count_d;
  logic         present_q, present_d;
  logic         charging_q, charging_d;
  logic         done_q, done_d;
  logic         out_valid_q;

  logic         accept;
  logic         run_end;
  logic [W-1:0] run_len;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d          = phase_q;
    high_run_d       = high_run_q;
    low_run_d        = low_run_q;
    valid_halves_d   = valid_halves_q;
    presence_count_d = presence_count_q;
    idle_count_d     = idle_count_q;
    present_d        = present_q;
    charging_d       = charging_q;
    done_d           = done_q;
    run_end          = 1'b0;
    run_len          = high_run_q;

    window_count_d = window_count_q + W'(1);

    if (!pin_level_i && (presence_count_q == '0)) begin
      if (idle_count_q != ctpd_pkg::CntMax) begin
        idle_count_d = idle_count_q + W'(1);
      end
      if (idle_count_d >= cfg.idle_timeout) begin
        idle_count_d = '0;
        charging_d   = 1'b0;
        done_d       = 1'b0;
      end
    end else begin
      idle_count_d = '0;
    end

    unique case (phase_q)
      ctpd_pkg::PH_HIGH: begin
        if (pin_level_i) begin
          if (high_run_q != ctpd_pkg::CntMax) begin
            high_run_d = high_run_q + W'(1);
          end
          low_run_d = '0;
        end else begin
          phase_d    = ctpd_pkg::PH_LOW;
          low_run_d  = W'(1);
          high_run_d = '0;
          run_end    = 1'b1;
          run_len    = high_run_q;
        end
      end
      ctpd_pkg::PH_LOW: begin
        if (!pin_level_i) begin
          if (low_run_q != ctpd_pkg::CntMax) begin
            low_run_d = low_run_q + W'(1);
          end
          high_run_d = '0;
        end else begin
          phase_d    = ctpd_pkg::PH_HIGH;
          high_run_d = W'(1);
          low_run_d  = '0;
          run_end    = 1'b1;
          run_len    = low_run_q;
        end
      end
      default: begin
        if (pin_level_i) begin
          phase_d    = ctpd_pkg::PH_HIGH;
          high_run_d = W'(1);
          low_run_d  = '0;
        end else begin
          phase_d    = ctpd_pkg::PH_LOW;
          high_run_d = '0;
          low_run_d  = W'(1);
        end
      end
    endcase

    if (run_end && (run_len >= cfg.half_period_min) && (run_len <= cfg.half_period_max)
        && (valid_halves_q != ctpd_pkg::CntMax)) begin
      valid_halves_d = valid_halves_q + W'(1);
    end

    if (window_count_d >= cfg.window_ticks) begin
      window_count_d = '0;
      if (valid_halves_d >= cfg.present_threshold) begin
        present_d = 1'b1;
      end else if (valid_halves_d <= cfg.absent_threshold) begin
        present_d = 1'b0;
      end
      valid_halves_d = '0;
    end

    if (present_d) begin
      if (presence_count_q != ctpd_pkg::CntMax) begin
        presence_count_d = presence_count_q + W'(1);
      end
      if (presence_count_d >= cfg.charging_confirm) begin
        charging_d = 1'b1;
      end
      if (presence_count_d >= cfg.done_confirm) begin
        done_d           = 1'b1;
        presence_count_d = cfg.done_confirm;
      end
    end else if (presence_count_q != '0) begin
      presence_count_d = presence_count_q - W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= ctpd_pkg::PH_INIT;
      high_run_q       <= '0;
      low_run_q        <= '0;
      window_count_q   <= '0;
      valid_halves_q   <= '0;
      presence_count_q <= '0;
      idle_count_q     <= '0;
      present_q        <= 1'b0;
      charging_q       <= 1'b0;
      done_q           <= 1'b0;
    end else if (accept) begin
      phase_q          <= phase_d;
      high_run_q       <= high_run_d;
      low_run_q        <= low_run_d;
      window_count_q   <= window_count_d;
      valid_halves_q   <= valid_halves_d;
      presence_count_q <= presence_count_d;
      idle_count_q     <= idle_count_d;
      present_q        <= present_d;
      charging_q       <= charging_d;
      done_q           <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign charging_o     = charging_q;
  assign charge_done_o  = done_q;
  assign tone_present_o = present_q;

endmodule

/* hw/rtl/ctpd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Charger tone presence detector register file
// Holds the eight configuration registers, written by index.
// ----------------------------------------------------------------------------
module ctpd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ctpd_pkg::RegIdxW-1:0]     cfg_index_i,
  input  logic [ctpd_pkg::CntW-1:0]        cfg_data_i,
  output ctpd_pkg::cfg_t                   cfg_o
);

  ctpd_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_min   <= ctpd_pkg::HalfPeriodMinRst;
      cfg_q.half_period_max   <= ctpd_pkg::HalfPeriodMaxRst;
      cfg_q.window_ticks      <= ctpd_pkg::WindowTicksRst;
      cfg_q.present_threshold <= ctpd_pkg::PresentThresholdRst;
      cfg_q.absent_threshold  <= ctpd_pkg::AbsentThresholdRst;
      cfg_q.charging_confirm  <= ctpd_pkg::ChargingConfirmRst;
      cfg_q.done_confirm      <= ctpd_pkg::DoneConfirmRst;
      cfg_q.idle_timeout      <= ctpd_pkg::IdleTimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (ctpd_pkg::reg_idx_e'(cfg_index_i))
        ctpd_pkg::REG_HALF_PERIOD_MIN:   cfg_q.half_period_min   <= cfg_data_i;
        ctpd_pkg::REG_HALF_PERIOD_MAX:   cfg_q.half_period_max   <= cfg_data_i;
        ctpd_pkg::REG_WINDOW_TICKS:      cfg_q.window_ticks      <= cfg_data_i;
        ctpd_pkg::REG_PRESENT_THRESHOLD: cfg_q.present_threshold <= cfg_data_i;
        ctpd_pkg::REG_ABSENT_THRESHOLD:  cfg_q.absent_threshold  <= cfg_data_i;
        ctpd_pkg::REG_CHARGING_CONFIRM:  cfg_q.charging_confirm  <= cfg_data_i;
        ctpd_pkg::REG_DONE_CONFIRM:      cfg_q.done_confirm      <= cfg_data_i;
        ctpd_pkg::REG_IDLE_TIMEOUT:      cfg_q.idle_timeout      <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule
